// ----- hdl/http_date_header_parser_defines.svh -----
// assertion helpers used by the date parser top module
`ifndef HTTP_DATE_HEADER_PARSER_DEFINES_SVH
`define HTTP_DATE_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hdp_pkg.sv -----
package hdp_pkg;

  // character codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_W  = 8'h57;
  localparam logic [7:0] CH_UP_J  = 8'h4A;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_O  = 8'h4F;
  localparam logic [7:0] CH_UP_N  = 8'h4E;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_R  = 8'h72;

  // line positions
  localparam logic [4:0] POS_LAST   = 5'd31;
  localparam logic [4:0] PREFIX_LEN = 5'd6;

  // field offsets after the optional prefix
  localparam logic [4:0] OFF_WDAY0 = 5'd0;
  localparam logic [4:0] OFF_WDAY1 = 5'd1;
  localparam logic [4:0] OFF_DAY0  = 5'd5;
  localparam logic [4:0] OFF_DAY1  = 5'd6;
  localparam logic [4:0] OFF_MON0  = 5'd8;
  localparam logic [4:0] OFF_MON1  = 5'd9;
  localparam logic [4:0] OFF_MON2  = 5'd10;
  localparam logic [4:0] OFF_YEAR0 = 5'd14;
  localparam logic [4:0] OFF_YEAR1 = 5'd15;
  localparam logic [4:0] OFF_HOUR0 = 5'd17;
  localparam logic [4:0] OFF_HOUR1 = 5'd18;
  localparam logic [4:0] OFF_MIN0  = 5'd20;
  localparam logic [4:0] OFF_MIN1  = 5'd21;
  localparam logic [4:0] OFF_SEC0  = 5'd23;
  localparam logic [4:0] OFF_SEC1  = 5'd24;

  // weekday codes
  localparam logic [2:0] WDAY_SUN = 3'd0;
  localparam logic [2:0] WDAY_MON = 3'd1;
  localparam logic [2:0] WDAY_TUE = 3'd2;
  localparam logic [2:0] WDAY_WED = 3'd3;
  localparam logic [2:0] WDAY_THU = 3'd4;
  localparam logic [2:0] WDAY_FRI = 3'd5;
  localparam logic [2:0] WDAY_SAT = 3'd6;

  // month codes
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_MAY = 4'd5;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_JUL = 4'd7;
  localparam logic [3:0] MON_AUG = 4'd8;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_OCT = 4'd10;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  // first-digit hold codes
  localparam logic [4:0] HOLD_SKIP  = 5'd10;
  localparam logic [4:0] HOLD_STOP  = 5'd11;
  localparam logic [4:0] HOLD_DIGIT = 5'd16;

  // range limits
  localparam logic [6:0] DAY_MAX = 7'd31;
  localparam logic [6:0] HOUR_MAX = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;

  // one decoded date line
  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [7:0] day_bcd;
    logic [2:0] weekday;
    logic [7:0] hour_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] second_bcd;
    logic       fields_valid;
  } hdp_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_0) && (c <= CH_9);
  endfunction

  // classify the first character of a two-character number
  function automatic logic [4:0] first_char(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_0;
    if (is_digit(c))
      first_char = HOLD_DIGIT | {1'b0, d[3:0]};
    else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
      first_char = HOLD_SKIP;
    else
      first_char = HOLD_STOP;
  endfunction

  // finish a number from the held first character and the second one
  function automatic logic [6:0] second_char(input logic [4:0] h, input logic [7:0] c);
    logic [7:0] cd;
    logic [6:0] d;
    cd = c - CH_0;
    d = {3'd0, h[3:0]};
    second_char = 7'd0;
    if ((h & HOLD_DIGIT) != 5'd0) begin
      if (is_digit(c))
        second_char = (d << 3) + (d << 1) + {3'd0, cd[3:0]};
      else
        second_char = d;
    end else if (h == HOLD_SKIP && is_digit(c)) begin
      second_char = {3'd0, cd[3:0]};
    end
  endfunction

  // binary 0..99 to packed bcd, tens by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens10;
    logic [6:0]  ones;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    tens10 = ({3'd0, tens} << 3) + ({3'd0, tens} << 1);
    ones = v - tens10;
    to_bcd = {tens, ones[3:0]};
  endfunction

endpackage

// ----- hdl/http_date_header_parser.sv -----
// HTTP date line parser: takes one character per item ("Date: Tue, 15 Nov 1994 08:12:31 GMT",
// the "Date: " prefix optional and detected by a leading 'D') and, on the last seconds
// digit, returns one item with the packed-BCD date and time, the weekday and a range
// flag; a line cut short by a new line_start gives no result, and characters after the
// result are ignored. One character is accepted every cycle while in_tready is high; out_tvalid
// rises once the last seconds digit has passed the input register and been decoded into
// the output register.
// in_tready drops only while the output register holds an untaken result and the
// registered character is waiting to advance.
`include "http_date_header_parser_defines.svh"

module http_date_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] line_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] year_bcd, [12:8] month_bcd, [20:13] day_bcd,
                                  // [23:21] weekday, [31:24] hour_bcd, [39:32] minute_bcd,
                                  // [47:40] second_bcd
  output logic        out_tuser   // [0] fields_valid
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_flag_r;

  logic                 step_go;
  logic                 emit;
  hdp_pkg::hdp_result_t result;

  // a held character advances when the output register can take a result
  assign step_go = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  hdp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step_go),
    .text_byte  (in_byte_r),
    .line_start (in_start_r),
    .emit       (emit),
    .result     (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && emit) begin
      out_data_r <= {result.second_bcd, result.minute_bcd, result.hour_bcd,
                     result.weekday, result.day_bcd, result.month_bcd, result.year_bcd};
      out_flag_r <= result.fields_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_flag_r;

  // checks
  `HDP_ASSERT_IMP(a_rise_from_step, $rose(out_valid_r), $past(step_go) && $past(emit),
    "result appeared without a decoded item")
  `HDP_ASSERT_IMP(a_no_overwrite, step_go && emit, !out_valid_r || out_tready,
    "result register overwritten while full")
  `HDP_ASSERT_IMP(a_valid_day, out_valid_r && out_flag_r, out_data_r[20:13] != 8'd0,
    "fields flagged valid with day zero")
  `HDP_ASSERT_IMP(a_month_range, out_valid_r,
    (out_data_r[12:8] != 5'd0) && (out_data_r[12] == 1'b0 || out_data_r[11:8] <= 4'd2),
    "month outside one to twelve")
  `HDP_ASSERT_NXT(a_held_step, in_valid_r && !step_go, in_valid_r,
    "held character lost before it advanced")

endmodule

// ----- hdl/hdp_parse.sv -----
module hdp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,        // consume one character this cycle
  input  logic [7:0]           text_byte,
  input  logic                 line_start,
  output logic                 emit,        // result ready on this step
  output hdp_pkg::hdp_result_t result
);

  logic [4:0] pos_r, pos_nxt;
  logic       prefix_r, prefix_nxt;
  logic [2:0] wday_r, wday_nxt;
  logic [3:0] month_r, month_nxt;
  logic [4:0] hold_r, hold_nxt;
  logic [6:0] day_r, day_nxt;
  logic [6:0] year_r, year_nxt;
  logic [6:0] hour_r, hour_nxt;
  logic [6:0] minute_r, minute_nxt;

  logic [4:0] pos;
  logic [4:0] off;
  logic [4:0] rel;
  logic [6:0] sec;

  // position of this character and the field it falls in
  always_comb begin
    pos = line_start ? 5'd0 : pos_r;
    prefix_nxt = (pos == 5'd0) ? (text_byte == hdp_pkg::CH_UP_D) : prefix_r;
    off = prefix_nxt ? hdp_pkg::PREFIX_LEN : 5'd0;
    rel = pos - off;
    pos_nxt = (pos < hdp_pkg::POS_LAST) ? pos + 5'd1 : pos;
  end

  // field decode
  always_comb begin
    wday_nxt = wday_r;
    month_nxt = month_r;
    hold_nxt = hold_r;
    day_nxt = day_r;
    year_nxt = year_r;
    hour_nxt = hour_r;
    minute_nxt = minute_r;
    emit = 1'b0;
    sec = hdp_pkg::second_char(hold_r, text_byte);
    if (pos >= off) begin
      case (rel)
        hdp_pkg::OFF_WDAY0: begin
          if (text_byte == hdp_pkg::CH_UP_T) wday_nxt = hdp_pkg::WDAY_THU;
          else if (text_byte == hdp_pkg::CH_UP_S) wday_nxt = hdp_pkg::WDAY_SUN;
          else if (text_byte == hdp_pkg::CH_UP_M) wday_nxt = hdp_pkg::WDAY_MON;
          else if (text_byte == hdp_pkg::CH_UP_W) wday_nxt = hdp_pkg::WDAY_WED;
          else wday_nxt = hdp_pkg::WDAY_FRI;
        end
        hdp_pkg::OFF_WDAY1: begin
          if (wday_r == hdp_pkg::WDAY_THU && text_byte == hdp_pkg::CH_LO_U)
            wday_nxt = hdp_pkg::WDAY_TUE;
          else if (wday_r == hdp_pkg::WDAY_SUN && text_byte == hdp_pkg::CH_LO_A)
            wday_nxt = hdp_pkg::WDAY_SAT;
        end
        hdp_pkg::OFF_DAY0, hdp_pkg::OFF_YEAR0, hdp_pkg::OFF_HOUR0,
        hdp_pkg::OFF_MIN0, hdp_pkg::OFF_SEC0: begin
          hold_nxt = hdp_pkg::first_char(text_byte);
        end
        hdp_pkg::OFF_DAY1:  day_nxt = sec;
        hdp_pkg::OFF_YEAR1: year_nxt = sec;
        hdp_pkg::OFF_HOUR1: hour_nxt = sec;
        hdp_pkg::OFF_MIN1:  minute_nxt = sec;
        hdp_pkg::OFF_MON0: begin
          if (text_byte == hdp_pkg::CH_UP_J) month_nxt = hdp_pkg::MON_JUL;
          else if (text_byte == hdp_pkg::CH_UP_F) month_nxt = hdp_pkg::MON_FEB;
          else if (text_byte == hdp_pkg::CH_UP_M) month_nxt = hdp_pkg::MON_MAY;
          else if (text_byte == hdp_pkg::CH_UP_A) month_nxt = hdp_pkg::MON_AUG;
          else if (text_byte == hdp_pkg::CH_UP_S) month_nxt = hdp_pkg::MON_SEP;
          else if (text_byte == hdp_pkg::CH_UP_O) month_nxt = hdp_pkg::MON_OCT;
          else if (text_byte == hdp_pkg::CH_UP_N) month_nxt = hdp_pkg::MON_NOV;
          else month_nxt = hdp_pkg::MON_DEC;
        end
        hdp_pkg::OFF_MON1: begin
          if (month_r == hdp_pkg::MON_JUL && text_byte == hdp_pkg::CH_LO_A)
            month_nxt = hdp_pkg::MON_JAN;
          else if (month_r == hdp_pkg::MON_AUG && text_byte == hdp_pkg::CH_LO_P)
            month_nxt = hdp_pkg::MON_APR;
        end
        hdp_pkg::OFF_MON2: begin
          if (month_r == hdp_pkg::MON_JUL && text_byte == hdp_pkg::CH_LO_N)
            month_nxt = hdp_pkg::MON_JUN;
          else if (month_r == hdp_pkg::MON_MAY && text_byte == hdp_pkg::CH_LO_R)
            month_nxt = hdp_pkg::MON_MAR;
        end
        hdp_pkg::OFF_SEC1:  emit = 1'b1;
        default: ;
      endcase
    end
  end

  // result assembly on the last seconds digit
  always_comb begin
    result.year_bcd = hdp_pkg::to_bcd(year_r);
    result.month_bcd = 5'(hdp_pkg::to_bcd({3'd0, month_r}));
    result.day_bcd = hdp_pkg::to_bcd(day_r);
    result.weekday = wday_r;
    result.hour_bcd = hdp_pkg::to_bcd(hour_r);
    result.minute_bcd = hdp_pkg::to_bcd(minute_r);
    result.second_bcd = hdp_pkg::to_bcd(sec);
    result.fields_valid = (day_r >= 7'd1) && (day_r <= hdp_pkg::DAY_MAX) &&
                          (hour_r <= hdp_pkg::HOUR_MAX) &&
                          (minute_r <= hdp_pkg::MINSEC_MAX) &&
                          (sec <= hdp_pkg::MINSEC_MAX);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
      prefix_r <= 1'b0;
      wday_r <= 3'd0;
      month_r <= 4'd0;
      hold_r <= 5'd0;
      day_r <= 7'd0;
      year_r <= 7'd0;
      hour_r <= 7'd0;
      minute_r <= 7'd0;
    end else if (step) begin
      pos_r <= pos_nxt;
      prefix_r <= prefix_nxt;
      wday_r <= wday_nxt;
      month_r <= month_nxt;
      hold_r <= hold_nxt;
      day_r <= day_nxt;
      year_r <= year_nxt;
      hour_r <= hour_nxt;
      minute_r <= minute_nxt;
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_CHARS = 300;
  localparam int TAIL_CYCLES = 10;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] text_byte
  logic        in_tuser;   // [0] line_start
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [7:0] year_bcd, [12:8] month_bcd, [20:13] day_bcd,
                           // [23:21] weekday, [31:24] hour_bcd, [39:32] minute_bcd,
                           // [47:40] second_bcd
  logic        out_tuser;  // [0] fields_valid

  http_date_header_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // date line decoder and store of expected decoded dates
  class date_scoreboard;
    hdp_pkg::hdp_result_t expected_dates[$];
    int errors;
    int used_chars;
    int results_seen;
    logic [4:0] line_pos;
    logic       date_tag;
    logic [2:0] wday;
    logic [3:0] month;
    logic [4:0] hold;
    logic [6:0] day;
    logic [6:0] year;
    logic [6:0] hour;
    logic [6:0] minute;

    function new();
      errors = 0;
      used_chars = 0;
      results_seen = 0;
      line_pos = 5'd0;
      date_tag = 1'b0;
      wday = hdp_pkg::WDAY_SUN;
      month = 4'd0;
      hold = 5'd0;
      day = 7'd0;
      year = 7'd0;
      hour = 7'd0;
      minute = 7'd0;
    endfunction

    function logic is_num(logic [7:0] c);
      return c >= hdp_pkg::CH_0 && c <= hdp_pkg::CH_9;
    endfunction

    // first character of a number: digit, skippable whitespace or stop
    function logic [4:0] hold_code(logic [7:0] c);
      if (is_num(c))
        return hdp_pkg::HOLD_DIGIT + 5'(c - hdp_pkg::CH_0);
      if (c == hdp_pkg::CH_SPACE || (c >= hdp_pkg::CH_TAB && c <= hdp_pkg::CH_CR))
        return hdp_pkg::HOLD_SKIP;
      return hdp_pkg::HOLD_STOP;
    endfunction

    // value of a two-character number given the held first character
    function logic [6:0] number_of(logic [4:0] h, logic [7:0] c);
      logic [6:0] units;
      logic [6:0] tens;
      units = 7'(c - hdp_pkg::CH_0);
      tens = 7'(h[3:0]);
      if ((h & hdp_pkg::HOLD_DIGIT) != 5'd0)
        return is_num(c) ? tens * 7'd10 + units : tens;
      if (h == hdp_pkg::HOLD_SKIP && is_num(c))
        return units;
      return 7'd0;
    endfunction

    function logic [7:0] bcd_of(logic [6:0] v);
      return {4'(v / 7'd10), 4'(v % 7'd10)};
    endfunction

    // advance the decoder by one accepted character
    function void note_char(logic [7:0] c, logic start);
      int rel;
      logic [6:0] sec;
      hdp_pkg::hdp_result_t r;
      if (start)
        line_pos = 5'd0;
      if (line_pos == 5'd0)
        date_tag = (c == hdp_pkg::CH_UP_D);
      rel = int'(line_pos) - (date_tag ? int'(hdp_pkg::PREFIX_LEN) : 0);
      if (rel <= int'(hdp_pkg::OFF_SEC1))
        used_chars++;
      case (rel)
        hdp_pkg::OFF_WDAY0: begin
          case (c)
            hdp_pkg::CH_UP_T: wday = hdp_pkg::WDAY_THU;
            hdp_pkg::CH_UP_S: wday = hdp_pkg::WDAY_SUN;
            hdp_pkg::CH_UP_M: wday = hdp_pkg::WDAY_MON;
            hdp_pkg::CH_UP_W: wday = hdp_pkg::WDAY_WED;
            default: wday = hdp_pkg::WDAY_FRI;
          endcase
        end
        hdp_pkg::OFF_WDAY1: begin
          if (wday == hdp_pkg::WDAY_THU && c == hdp_pkg::CH_LO_U)
            wday = hdp_pkg::WDAY_TUE;
          else if (wday == hdp_pkg::WDAY_SUN && c == hdp_pkg::CH_LO_A)
            wday = hdp_pkg::WDAY_SAT;
        end
        hdp_pkg::OFF_DAY0, hdp_pkg::OFF_YEAR0, hdp_pkg::OFF_HOUR0,
        hdp_pkg::OFF_MIN0, hdp_pkg::OFF_SEC0: hold = hold_code(c);
        hdp_pkg::OFF_DAY1: day = number_of(hold, c);
        hdp_pkg::OFF_YEAR1: year = number_of(hold, c);
        hdp_pkg::OFF_HOUR1: hour = number_of(hold, c);
        hdp_pkg::OFF_MIN1: minute = number_of(hold, c);
        hdp_pkg::OFF_MON0: begin
          case (c)
            hdp_pkg::CH_UP_J: month = hdp_pkg::MON_JUL;
            hdp_pkg::CH_UP_F: month = hdp_pkg::MON_FEB;
            hdp_pkg::CH_UP_M: month = hdp_pkg::MON_MAY;
            hdp_pkg::CH_UP_A: month = hdp_pkg::MON_AUG;
            hdp_pkg::CH_UP_S: month = hdp_pkg::MON_SEP;
            hdp_pkg::CH_UP_O: month = hdp_pkg::MON_OCT;
            hdp_pkg::CH_UP_N: month = hdp_pkg::MON_NOV;
            default: month = hdp_pkg::MON_DEC;
          endcase
        end
        hdp_pkg::OFF_MON1: begin
          if (month == hdp_pkg::MON_JUL && c == hdp_pkg::CH_LO_A)
            month = hdp_pkg::MON_JAN;
          else if (month == hdp_pkg::MON_AUG && c == hdp_pkg::CH_LO_P)
            month = hdp_pkg::MON_APR;
        end
        hdp_pkg::OFF_MON2: begin
          if (month == hdp_pkg::MON_JUL && c == hdp_pkg::CH_LO_N)
            month = hdp_pkg::MON_JUN;
          else if (month == hdp_pkg::MON_MAY && c == hdp_pkg::CH_LO_R)
            month = hdp_pkg::MON_MAR;
        end
        hdp_pkg::OFF_SEC1: begin
          sec = number_of(hold, c);
          r.year_bcd = bcd_of(year);
          r.month_bcd = 5'(bcd_of({3'd0, month}));
          r.day_bcd = bcd_of(day);
          r.weekday = wday;
          r.hour_bcd = bcd_of(hour);
          r.minute_bcd = bcd_of(minute);
          r.second_bcd = bcd_of(sec);
          r.fields_valid = day >= 7'd1 && day <= hdp_pkg::DAY_MAX &&
                           hour <= hdp_pkg::HOUR_MAX &&
                           minute <= hdp_pkg::MINSEC_MAX && sec <= hdp_pkg::MINSEC_MAX;
          expected_dates.push_back(r);
        end
        default: ;
      endcase
      if (line_pos != hdp_pkg::POS_LAST)
        line_pos = line_pos + 5'd1;
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted decoded date with the oldest expectation
    function void check_result(logic [47:0] d, logic u);
      hdp_pkg::hdp_result_t e;
      results_seen++;
      if (expected_dates.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual %h/%b",
                 $time, d, u);
        errors++;
        return;
      end
      e = expected_dates.pop_front();
      compare("year_bcd", 32'(e.year_bcd), 32'(d[7:0]));
      compare("month_bcd", 32'(e.month_bcd), 32'(d[12:8]));
      compare("day_bcd", 32'(e.day_bcd), 32'(d[20:13]));
      compare("weekday", 32'(e.weekday), 32'(d[23:21]));
      compare("hour_bcd", 32'(e.hour_bcd), 32'(d[31:24]));
      compare("minute_bcd", 32'(e.minute_bcd), 32'(d[39:32]));
      compare("second_bcd", 32'(e.second_bcd), 32'(d[47:40]));
      compare("fields_valid", 32'(e.fields_valid), 32'(u));
    endfunction
  endclass

  date_scoreboard sb = new();

  string wday_names[7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};
  string month_names[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                             "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
  string odd_months[5] = '{"Jxn", "Jux", "Max", "Mxr", "Axe"};
  int idle_mix[4] = '{0, 69, 0, 37};
  int stall_mix[4] = '{0, 0, 69, 37};

  int send_idle = 0;
  int recv_stall = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int lines_sent = 0;
  logic [7:0] line_buf[$];

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  // offer one character item and wait for it to be taken
  task automatic send_item(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= s;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    sb.note_char(b, s);
  endtask

  task automatic send_bytes(input logic [7:0] q[$], input logic start);
    foreach (q[i])
      send_item(q[i], start && i == 0);
    lines_sent++;
  endtask

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++)
      line_buf.push_back(s[i]);
  endfunction

  task automatic send_text(input string s, input logic start);
    line_buf.delete();
    add_text(s);
    send_bytes(line_buf, start);
  endtask

  // two characters of a number: mostly digits, some whitespace, signs and junk
  function void add_number(int maxv);
    int r;
    int v;
    r = $urandom_range(99);
    v = $urandom_range(maxv);
    if (r < 72) begin
      line_buf.push_back(hdp_pkg::CH_0 + 8'(v / 10));
      line_buf.push_back(hdp_pkg::CH_0 + 8'(v % 10));
    end else if (r < 84) begin
      v = $urandom_range(5);
      line_buf.push_back(v == 5 ? hdp_pkg::CH_SPACE : hdp_pkg::CH_TAB + 8'(v));
      line_buf.push_back(hdp_pkg::CH_0 + 8'($urandom_range(9)));
    end else if (r < 90) begin
      line_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
      line_buf.push_back(hdp_pkg::CH_0 + 8'($urandom_range(9)));
    end else if (r < 94) begin
      line_buf.push_back(hdp_pkg::CH_0 + 8'($urandom_range(9)));
      line_buf.push_back(8'($urandom_range(255)));
    end else begin
      line_buf.push_back(8'($urandom_range(255)));
      line_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  // one mostly well-formed date line, sometimes cut short
  task automatic send_random_line();
    int r;
    int off;
    int keep;
    line_buf.delete();
    r = $urandom_range(99);
    if (r < 45) begin
      add_text("Date: ");
    end else if (r < 55) begin
      line_buf.push_back(hdp_pkg::CH_UP_D);
      repeat (5) line_buf.push_back(8'($urandom_range(255)));
    end
    off = (line_buf.size() != 0) ? int'(hdp_pkg::PREFIX_LEN) : 0;
    if ($urandom_range(99) < 85)
      add_text(wday_names[$urandom_range(6)]);
    else
      repeat (3) line_buf.push_back(8'($urandom_range(255)));
    add_text(", ");
    add_number(40);
    add_text(" ");
    r = $urandom_range(99);
    if (r < 80)
      add_text(month_names[$urandom_range(11)]);
    else if (r < 90)
      add_text(odd_months[$urandom_range(4)]);
    else
      repeat (3) line_buf.push_back(8'($urandom_range(255)));
    add_text(" 20");
    add_number(99);
    add_text(" ");
    add_number(30);
    add_text(":");
    add_number(70);
    add_text(":");
    add_number(70);
    if ($urandom_range(99) < 10) begin
      keep = $urandom_range(off + int'(hdp_pkg::OFF_SEC1), 1);
      while (line_buf.size() > keep)
        void'(line_buf.pop_back());
    end else begin
      repeat ($urandom_range(6)) line_buf.push_back(8'($urandom_range(255)));
    end
    send_bytes(line_buf, $urandom_range(99) < 95);
  endtask

  // stop offering and wait for every expected date to come out
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.expected_dates.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    int target;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'd0;
    in_tuser <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed lines: first one without line_start right after reset
    send_text("Date: Tue, 15 Nov 1994 08:12:31 GMT", 1'b0);
    send_text("Thu, 01 Jan 2000 00:00:00 GMT", 1'b1);
    send_text("Sat, 31 Jun 2099 23:59:59", 1'b1);
    send_text("Date: Sun, 00 Jul 2045 24:60:60", 1'b1);
    send_text("Mon, 99 Feb 2012 99:99:99", 1'b1);
    // leading blanks, signs, stray letters, other weekday letter
    send_text("Wed,  7 Mar 2007  9: 5: 3", 1'b1);
    send_text("Fri, -5 May 2010 +1:2x:\t8", 1'b1);
    send_text("Xyz, 1a Apr 2020 ab:12:34", 1'b1);
    // line cut short by a restart, then trailing bytes after a result
    send_text("Date: Tue, 15 Au", 1'b1);
    send_text("Date: Thu, 12 Aug 2022 12:34:56 trailing junk", 1'b1);
    send_text("Sun, 10 Sep 2023 01:02:03", 1'b1);
    send_text("Mon, 11 Oct 2024 02:03:04", 1'b1);
    send_text("Tue, 13 Qqq 2025\n3:\0154:\0145", 1'b1);
    send_text("Wed, 14 Dec 2026 10:20:30", 1'b1);
    send_text("Sat, 09 Jux 2001 05:06:07", 1'b1);
    wait_results();

    // random lines under each idle and stall mix
    target = sb.used_chars;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_mix[ph];
      recv_stall = stall_mix[ph];
      target += PHASE_CHARS;
      while (sb.used_chars < target) begin
        if ($urandom_range(99) < 8) begin
          line_buf.delete();
          repeat ($urandom_range(5, 1)) line_buf.push_back(8'($urandom_range(255)));
          send_bytes(line_buf, 1'($urandom_range(1)));
        end else begin
          send_random_line();
        end
      end
      wait_results();
      if (ph == 0) begin
        // long receiver hold-off while lines keep coming
        send_idle = 0;
        holds_asked = holds_asked + 1;
        repeat (4) send_random_line();
        wait_results();
      end
    end

    $display("checked %0d decoded dates from %0d lines (%0d parsed characters)",
             sb.results_seen, lines_sent, sb.used_chars);
    $display("under free-running, sender-idle, receiver-stall and mixed traffic");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
